// ===== src/itoa_pkg.sv =====
// shared constants and types for the integer to ascii formatter
package itoa_pkg;

  // number of value bits in use
  localparam int unsigned VALUE_WIDTH = 32;
  // decimal digits needed for the widest value
  localparam int unsigned DEC_DIGITS  = 10;
  // character shift register width, one nibble per decimal digit
  localparam int unsigned SR_W        = 4 * DEC_DIGITS;
  // counter wide enough for the largest digit count
  localparam int unsigned REM_W       = $clog2(VALUE_WIDTH + 1);
  // iteration counter of the decimal converter
  localparam int unsigned CNT_W       = $clog2(VALUE_WIDTH + 1);

  localparam logic [5:0] ASCII_ZERO = 6'd48;

  // format selector carried in tuser
  typedef enum logic [1:0] {
    OP_BIN_AUTO = 2'd0,
    OP_BIN_16   = 2'd1,
    OP_DEC      = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef logic [SR_W-1:0] bcd_t;

endpackage

// ===== src/itoa_dec_conv.sv =====
// serial binary to bcd converter, one value bit per cycle (shift and add three)
module itoa_dec_conv (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [itoa_pkg::VALUE_WIDTH-1:0]    value_i,
  output logic                                done_o,
  output itoa_pkg::bcd_t                      bcd_o
);
  import itoa_pkg::*;

  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  bcd_t                   bcd_q, bcd_d, bcd_adj;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = value_i;
      bcd_d  = '0;
      cnt_d  = CNT_W'(VALUE_WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {bcd_adj[SR_W-2:0], bin_q[VALUE_WIDTH-1]};
      bin_d = {bin_q[VALUE_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

// ===== src/integer_to_ascii_formatter_top.sv =====
// top level of the integer to ascii formatter
//
// input channel s_axis: one transaction carries a 32-bit unsigned value in
// tdata and the format in tuser (0 binary auto width, 1 binary 16 digits,
// 2 decimal, 3 gives no characters). output channel m_axis: one transaction
// per ascii character, most significant first, tlast on the final one.
// binary: the value is loaded into the character shift register and the
// characters go to the output register at one per cycle while the
// receiver takes them; 8, 16 or 32 characters, and the next value can be
// taken once the final one is registered. decimal: the serial bcd
// converter takes one value bit per cycle and then hands its digits over;
// the ten digit positions are then walked at one per cycle while the
// receiver takes the digits sent, a leading zero being dropped unless it
// is in the last position and any other digit sent; the next value can be
// taken once the final digit is registered.
// s_axis_tready is high while no value is in work, including the cycles in
// which the final character still waits in the output register.
// when the receiver stalls, the output register holds its character and
// the character shift register stops; leading decimal zeros still drop.
// reset (rst_ni low, asynchronous) returns to idle, no character pending.
module integer_to_ascii_formatter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [5:0] char_code, [7:6] zero
  output logic        m_axis_tlast    // last
);
  import itoa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BIN,
    ST_DCONV,
    ST_DEMIT
  } state_e;

  state_e                 state_q, state_d;
  bcd_t                   sr_q, sr_d;         // characters, most significant at the top
  logic [REM_W-1:0]       rem_q, rem_d;       // characters or digits still to go
  logic                   started_q, started_d; // a decimal digit has been sent
  logic                   m_valid_q, m_valid_d;
  logic [5:0]             m_char_q, m_char_d;
  logic                   m_last_q, m_last_d;

  logic [VALUE_WIDTH-1:0] val_m;
  op_e                    op_in;
  logic                   s_fire;
  logic                   can_load;
  logic                   dec_start;
  logic                   dec_done;
  bcd_t                   dec_bcd;
  logic [3:0]             top_nib;
  logic                   dig_emit;

  assign val_m    = s_axis_tdata[VALUE_WIDTH-1:0];
  assign op_in    = op_e'(s_axis_tuser);
  assign s_fire   = s_axis_tvalid && s_axis_tready;
  // output register free now or freed by this cycle's transaction
  assign can_load = !m_valid_q || m_axis_tready;
  assign top_nib  = sr_q[SR_W-1 -: 4];
  // leading zeros are dropped, but a lone zero is still shown
  assign dig_emit = started_q || (top_nib != 4'd0) || (rem_q == REM_W'(1));
  assign dec_start = s_fire && (op_in == OP_DEC);

  itoa_dec_conv u_dec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dec_start),
    .value_i (val_m),
    .done_o  (dec_done),
    .bcd_o   (dec_bcd)
  );

  always_comb begin
    state_d   = state_q;
    sr_d      = sr_q;
    rem_d     = rem_q;
    started_d = started_q;
    m_valid_d = m_valid_q;
    m_char_d  = m_char_q;
    m_last_d  = m_last_q;

    // drop the character once the receiver has taken it
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          case (op_in)
            OP_BIN_AUTO: begin
              state_d = ST_BIN;
              if (32'(val_m) > 32'd65535) begin
                sr_d  = {val_m, {(SR_W-VALUE_WIDTH){1'b0}}};
                rem_d = REM_W'(VALUE_WIDTH);
              end else if (32'(val_m) > 32'd255) begin
                sr_d  = {val_m[15:0], {(SR_W-16){1'b0}}};
                rem_d = REM_W'(16);
              end else begin
                sr_d  = {val_m[7:0], {(SR_W-8){1'b0}}};
                rem_d = REM_W'(8);
              end
            end
            OP_BIN_16: begin
              state_d = ST_BIN;
              sr_d    = {val_m[15:0], {(SR_W-16){1'b0}}};
              rem_d   = REM_W'(16);
            end
            OP_DEC: begin
              state_d = ST_DCONV;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_BIN: begin
        if (can_load) begin
          m_valid_d = 1'b1;
          m_char_d  = ASCII_ZERO + {5'd0, sr_q[SR_W-1]};
          m_last_d  = (rem_q == REM_W'(1));
          sr_d      = {sr_q[SR_W-2:0], 1'b0};
          rem_d     = rem_q - 1'b1;
          if (rem_q == REM_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_DCONV: begin
        if (dec_done) begin
          sr_d      = dec_bcd;
          rem_d     = REM_W'(DEC_DIGITS);
          started_d = 1'b0;
          state_d   = ST_DEMIT;
        end
      end

      ST_DEMIT: begin
        if (!dig_emit || can_load) begin
          if (dig_emit) begin
            m_valid_d = 1'b1;
            m_char_d  = ASCII_ZERO + {2'd0, top_nib};
            m_last_d  = (rem_q == REM_W'(1));
            started_d = 1'b1;
          end
          sr_d  = {sr_q[SR_W-5:0], 4'd0};
          rem_d = rem_q - 1'b1;
          if (rem_q == REM_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rem_q     <= '0;
      started_q <= 1'b0;
      m_valid_q <= 1'b0;
      sr_q      <= '0;
      m_char_q  <= ASCII_ZERO;
      m_last_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      rem_q     <= rem_d;
      started_q <= started_d;
      m_valid_q <= m_valid_d;
      sr_q      <= sr_d;
      m_char_q  <= m_char_d;
      m_last_q  <= m_last_d;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, m_char_q};
  assign m_axis_tlast  = m_last_q;

endmodule

// ===== src/itoa_checker.sv =====
// port level checks for the integer to ascii formatter, bound to the top level
module itoa_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [1:0] s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);
  import itoa_pkg::*;

  // a pending output transaction stays valid until the receiver takes it
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transaction dropped while stalled");

  // no new value is taken while a string is still partly out
  a_no_accept_mid_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready in the middle of a string");

  // every character is an ascii digit
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:6] == 2'b00) && (m_axis_tdata[5:0] >= 6'd48)
                      && (m_axis_tdata[5:0] <= 6'd57))
    else $error("character outside the digit range");

  // a value with a defined format keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_NONE) |=> !s_axis_tready)
    else $error("input ready right after a value was taken");

endmodule

bind integer_to_ascii_formatter_top itoa_checker u_itoa_checker (.*);

// ===== verif/tb_integer_to_ascii_formatter_top.sv =====
// self-checking testbench for the integer to ascii formatter top level
module tb_integer_to_ascii_formatter_top;
  import itoa_pkg::*;

  // cycles without any transaction before the run is declared hung
  localparam int unsigned HANG_LIMIT   = 2000;
  // drain time after the last expected character
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned RANDOM_ITEMS = 320;

  typedef struct packed {
    logic [5:0] code;
    logic       last;
  } ascii_char_t;

  // one row of the directed table; typed rows carry their text literally
  typedef struct {
    logic [31:0] value;
    op_e         op;
    bit          typed;
    string       text;
  } text_case_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] value
  logic [1:0]  s_axis_tuser;   // [1:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [5:0] char_code, [7:6] zero
  logic        m_axis_tlast;   // last

  integer_to_ascii_formatter_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // characters still owed by the block, oldest first
  ascii_char_t pending_chars[$];
  text_case_t  directed_cases[$];

  // fields of the number currently offered on the input channel
  logic [31:0] cur_value;
  op_e         cur_op;
  bit          cur_typed;
  string       cur_text;

  // when set, neither side inserts idle cycles
  bit          no_idle;

  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned chars_checked;
  int unsigned numbers_by_op[4];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // expected text of one number, one character per entry
  function automatic void predict_text(input logic [31:0] value, input op_e op);
    int unsigned width;
    int unsigned digits[10];
    int unsigned ndig;
    int unsigned rest;
    ascii_char_t c;
    case (op)
      OP_BIN_AUTO, OP_BIN_16: begin
        if (op == OP_BIN_16) begin
          width = 16;
        end else if (value > 32'd65535) begin
          width = VALUE_WIDTH;
        end else if (value > 32'd255) begin
          width = 16;
        end else begin
          width = 8;
        end
        for (int pos = width; pos > 0; pos--) begin
          c.code = ASCII_ZERO + 6'(value[pos-1]);
          c.last = (pos == 1);
          pending_chars.push_back(c);
        end
      end
      OP_DEC: begin
        // zero still gives one digit
        rest = value;
        ndig = 0;
        do begin
          digits[ndig] = rest % 10;
          rest         = rest / 10;
          ndig++;
        end while (rest != 0);
        for (int k = ndig; k > 0; k--) begin
          c.code = ASCII_ZERO + 6'(digits[k-1]);
          c.last = (k == 1);
          pending_chars.push_back(c);
        end
      end
      default: begin
        // unused code: no characters at all
      end
    endcase
  endfunction

  // expectation written out as a literal string
  function automatic void push_text(input string text);
    ascii_char_t c;
    for (int i = 0; i < text.len(); i++) begin
      c.code = 6'(text[i]);
      c.last = (i == text.len() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  function automatic void add_case(input logic [31:0] value, input op_e op,
                                   input bit typed, input string text);
    text_case_t t;
    t.value = value;
    t.op    = op;
    t.typed = typed;
    t.text  = text;
    directed_cases.push_back(t);
  endfunction

  // offer one number on the input channel and wait for its transaction
  task automatic send_number(input logic [31:0] value, input op_e op,
                             input bit typed, input string text);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cur_value     = value;
    cur_op        = op;
    cur_typed     = typed;
    cur_text      = text;
    s_axis_tdata  = value;
    s_axis_tuser  = op;
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // hold off the sender until every owed character has come out
  task automatic wait_for_drain();
    while (pending_chars.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // input and output transactions are both observed here, at the rising edge
  always @(posedge clk_i) begin
    ascii_char_t want;
    if (rst_ni) begin
      idle_cycles = idle_cycles + 1;
      if (s_axis_tvalid && s_axis_tready) begin
        idle_cycles = 0;
        numbers_by_op[cur_op] = numbers_by_op[cur_op] + 1;
        if (cur_typed) begin
          push_text(cur_text);
        end else begin
          predict_text(cur_value, cur_op);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        idle_cycles = 0;
        if (pending_chars.size() == 0) begin
          $error("unexpected character: char_code %0d last %0b",
                 m_axis_tdata[5:0], m_axis_tlast);
          error_count++;
        end else begin
          want = pending_chars.pop_front();
          chars_checked++;
          if (m_axis_tdata[5:0] !== want.code) begin
            $error("char_code: expected %0d, actual %0d", want.code, m_axis_tdata[5:0]);
            error_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, m_axis_tlast);
            error_count++;
          end
          if (m_axis_tdata[7:6] !== 2'b00) begin
            $error("tdata pad: expected 0, actual %0d", m_axis_tdata[7:6]);
            error_count++;
          end
        end
      end
    end
  end

  // hang detection
  initial begin
    while (idle_cycles < HANG_LIMIT) @(posedge clk_i);
    $display("integer_to_ascii_formatter_top: mismatch");
    $finish;
  end

  // receiver: random stalls before each character, none while no_idle is set
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // sender and run control
  initial begin
    int unsigned powers[10];
    int unsigned sent;
    int unsigned sel;
    int unsigned pick;
    logic [31:0] value;
    op_e         op;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cur_value     = '0;
    cur_op        = OP_BIN_AUTO;
    cur_typed     = 1'b0;
    cur_text      = "";
    no_idle       = 1'b0;
    error_count   = 0;
    idle_cycles   = 0;
    chars_checked = 0;
    foreach (numbers_by_op[i]) numbers_by_op[i] = 0;

    powers[0] = 1;
    for (int k = 1; k < 10; k++) powers[k] = powers[k-1] * 10;

    // auto width boundaries, both binary modes, decimal length edges,
    // decimal zero and the unused code
    add_case(32'd0,          OP_BIN_AUTO, 1, "00000000");
    add_case(32'd255,        OP_BIN_AUTO, 1, "11111111");
    add_case(32'd256,        OP_BIN_AUTO, 0, "");
    add_case(32'd65535,      OP_BIN_AUTO, 1, "1111111111111111");
    add_case(32'd65536,      OP_BIN_AUTO, 0, "");
    add_case(32'hFFFF_FFFF,  OP_BIN_AUTO, 1, "11111111111111111111111111111111");
    add_case(32'h8000_0001,  OP_BIN_AUTO, 0, "");
    add_case(32'd0,          OP_BIN_16,   1, "0000000000000000");
    add_case(32'h0000_FFFF,  OP_BIN_16,   1, "1111111111111111");
    add_case(32'hFFFF_0000,  OP_BIN_16,   1, "0000000000000000");
    add_case(32'hA5A5_5A5A,  OP_BIN_16,   0, "");
    add_case(32'd0,          OP_DEC,      1, "0");
    add_case(32'd1,          OP_DEC,      1, "1");
    add_case(32'd9,          OP_DEC,      1, "9");
    add_case(32'd10,         OP_DEC,      1, "10");
    add_case(32'd999999999,  OP_DEC,      1, "999999999");
    add_case(32'd1000000000, OP_DEC,      1, "1000000000");
    add_case(32'hFFFF_FFFF,  OP_DEC,      1, "4294967295");
    add_case(32'h1234_5678,  OP_DEC,      0, "");
    add_case(32'd0,          OP_NONE,     1, "");
    add_case(32'hFFFF_FFFF,  OP_NONE,     1, "");
    add_case(32'd1234,       OP_BIN_AUTO, 0, "");

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_cases[i]) begin
      send_number(directed_cases[i].value, directed_cases[i].op,
                  directed_cases[i].typed, directed_cases[i].text);
    end
    s_axis_tvalid = 1'b0;
    wait_for_drain();

    // random part; numbers with the unused code do not count
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (sent == RANDOM_ITEMS / 2) begin
        s_axis_tvalid = 1'b0;
        wait_for_drain();
      end
      sel = $urandom_range(0, 4);
      case (sel)
        0: value = $urandom;
        1: value = $urandom_range(0, 255);
        2: value = $urandom_range(256, 65535);
        3: begin
          // around a power of ten, where the decimal length changes
          pick  = $urandom_range(0, 9);
          value = powers[pick] + $urandom_range(0, 2) - 1;
        end
        default: value = $urandom_range(32'hFFFF_FFFF, 65536);
      endcase
      pick = $urandom_range(0, 15);
      if (pick == 15) begin
        op = OP_NONE;
      end else begin
        op = op_e'(pick % 3);
        sent++;
      end
      send_number(value, op, 0, "");
    end
    s_axis_tvalid = 1'b0;
    no_idle       = 1'b0;

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_chars.size() != 0) begin
      $error("%0d characters never arrived", pending_chars.size());
      error_count++;
    end

    $display("covered %0d binary auto, %0d binary 16, %0d decimal, %0d unused-code numbers",
             numbers_by_op[OP_BIN_AUTO], numbers_by_op[OP_BIN_16],
             numbers_by_op[OP_DEC], numbers_by_op[OP_NONE]);
    $display("checked %0d characters with random stalls on both channels", chars_checked);
    if (error_count == 0) begin
      $display("integer_to_ascii_formatter_top: match");
    end else begin
      $display("integer_to_ascii_formatter_top: mismatch");
    end
    $finish;
  end

endmodule
